FILE: rtl/egc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// egc_pkg
// Types and constants for the equatorial / galactic coordinate converter.
// ---------------------------------------------------------------------------
package egc_pkg;

  // datapath width for Q4.30 values and binary angle accumulators
  localparam int CW = 34;
  localparam int MAX_STAGES = 40;
  localparam int QONE_SHIFT = 30;

  localparam logic [63:0] POLE_RA_W =
      ((64'd19285948 << 32) + 64'd18000000) / 64'd36000000;
  localparam logic [63:0] POLE_DEC_W =
      ((64'd2712825 << 32) + 64'd18000000) / 64'd36000000;
  localparam logic [63:0] NODE_LON_W =
      ((64'd122931918 << 32) + 64'd180000000) / 64'd360000000;

  localparam logic [31:0] POLE_RA  = POLE_RA_W[31:0];
  localparam logic [31:0] POLE_DEC = POLE_DEC_W[31:0];
  localparam logic [31:0] NODE_LON = NODE_LON_W[31:0];

  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER  = 34'sd1073741824;

  localparam logic CMD_TO_GAL = 1'b0;
  localparam logic CMD_TO_EQU = 1'b1;

  typedef struct packed {
    logic              command;
    logic [31:0]       lon_in;
    logic signed [31:0] lat_in;
  } item_t;

  typedef struct packed {
    logic [31:0]        lon_out;
    logic signed [31:0] lat_out;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] acc;
  } vec_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic signed [CW-1:0] atan_bam(input int unsigned idx);
    logic signed [CW-1:0] a;
    case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      24: a = 34'sd41;
      25: a = 34'sd20;
      26: a = 34'sd10;
      27: a = 34'sd5;
      28: a = 34'sd3;
      29: a = 34'sd1;
      30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/equatorial_galactic_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// equatorial_galactic_convert
// Pipelined sky rotation between equatorial and galactic coordinates.
// ---------------------------------------------------------------------------
// channel  | signals                              | payload
// item     | item_valid, item_stall, item         | command, lon_in, lat_in
// result   | result_valid, result_stall, result   | lon_out, lat_out
//
// one item per cycle while the result is not stalled; the three CORDIC
// pipelines (sin/cos, angle, latitude) run in series
// rst clears all stage valid bits; payload registers are not reset
// a stalled result freezes the whole pipeline, item_stall follows it
module equatorial_galactic_convert
  import egc_pkg::*;
#(
  parameter int CORDIC_STAGES = 32
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  wire     result_stall,
  output result_t result
);

  localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  function automatic logic [CW:0] fold_angle(input logic [31:0] ang);
    logic [31:0] q;
    logic [31:0] t;
    logic        flip;
    q    = ang + 32'h4000_0000;
    flip = q[31];
    t    = flip ? ang + 32'h8000_0000 : ang;
    return {flip, {{(CW-32){t[31]}}, t}};
  endfunction

  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p[CW+QONE_SHIFT-1:QONE_SHIFT];
  endfunction

  function automatic vec_t vec_fold(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    vec_t v;
    v.x   = x;
    v.y   = y;
    v.acc = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x   = y;
        v.y   = -x;
        v.acc = QUARTER;
      end else begin
        v.x   = -y;
        v.y   = x;
        v.acc = -QUARTER;
      end
    end
    return v;
  endfunction

  logic run;
  assign run        = !(result_valid && result_stall);
  assign item_stall = !run;

  // ---------------- sin/cos: channel 0 latitude, 1 hour angle, 2 pole ----
  logic signed [CW-1:0] rx [3][0:N];
  logic signed [CW-1:0] ry [3][0:N];
  logic signed [CW-1:0] rz [3][0:N];
  logic                 rflip [3][0:N];
  logic                 rcmd [0:N];
  logic                 rvld [0:N];

  logic [31:0] h_ang;
  assign h_ang = (item.command == CMD_TO_EQU) ? NODE_LON - item.lon_in
                                              : item.lon_in - POLE_RA;

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld[0] <= 1'b0;
    end else if (run) begin
      rvld[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      {rflip[0][0], rz[0][0]} <= fold_angle(item.lat_in);
      {rflip[1][0], rz[1][0]} <= fold_angle(h_ang);
      {rflip[2][0], rz[2][0]} <= fold_angle(POLE_DEC);
      rx[0][0] <= INV_GAIN;
      rx[1][0] <= INV_GAIN;
      rx[2][0] <= INV_GAIN;
      ry[0][0] <= '0;
      ry[1][0] <= '0;
      ry[2][0] <= '0;
      rcmd[0]  <= item.command;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rvld[i+1] <= 1'b0;
      end else if (run) begin
        rvld[i+1] <= rvld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (run) begin
        rcmd[i+1] <= rcmd[i];
      end
    end
    for (genvar c = 0; c < 3; c++) begin : g_ch
      always_ff @(posedge clk) begin
        if (run) begin
          rflip[c][i+1] <= rflip[c][i];
          if (rz[c][i] >= 0) begin
            rx[c][i+1] <= rx[c][i] - (ry[c][i] >>> i);
            ry[c][i+1] <= ry[c][i] + (rx[c][i] >>> i);
            rz[c][i+1] <= rz[c][i] - atan_bam(i);
          end else begin
            rx[c][i+1] <= rx[c][i] + (ry[c][i] >>> i);
            ry[c][i+1] <= ry[c][i] - (rx[c][i] >>> i);
            rz[c][i+1] <= rz[c][i] + atan_bam(i);
          end
        end
      end
    end
  end

  logic signed [CW-1:0] sd, cd, sh, ch, sp, cp;
  assign sd = rflip[0][N] ? -ry[0][N] : ry[0][N];
  assign cd = rflip[0][N] ? -rx[0][N] : rx[0][N];
  assign sh = rflip[1][N] ? -ry[1][N] : ry[1][N];
  assign ch = rflip[1][N] ? -rx[1][N] : rx[1][N];
  assign sp = rflip[2][N] ? -ry[2][N] : ry[2][N];
  assign cp = rflip[2][N] ? -rx[2][N] : rx[2][N];

  // ---------------- products ----------------------------------------------
  logic signed [CW-1:0] cdch, spsd, cpsd, yv1, sp1, cp1;
  logic                 m1_cmd, m1_vld;
  logic signed [CW-1:0] z2, x2, y2;
  logic                 m2_cmd, m2_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else if (run) begin
      m1_vld <= rvld[N];
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      cdch   <= qmul(cd, ch);
      spsd   <= qmul(sp, sd);
      cpsd   <= qmul(cp, sd);
      yv1    <= qmul(cd, sh);
      sp1    <= sp;
      cp1    <= cp;
      m1_cmd <= rcmd[N];
      z2     <= spsd + qmul(cp1, cdch);
      x2     <= cpsd - qmul(sp1, cdch);
      y2     <= yv1;
      m2_cmd <= m1_cmd;
    end
  end

  // ---------------- vectoring: channel 0 longitude, 1 latitude ------------
  logic signed [CW-1:0] vx [2][0:N];
  logic signed [CW-1:0] vy [2][0:N];
  logic signed [CW-1:0] vacc [2][0:N];
  logic signed [CW-1:0] vaux [2][0:N];
  logic                 vzero [2][0:N];
  logic                 vcmd [2][0:N];
  logic                 vvld [2][0:N];

  logic signed [CW-1:0] r_g, ang_g, z_g;
  logic                 g_cmd, g_vld;

  vec_t f0, f1;
  assign f0 = vec_fold(x2, y2);
  assign f1 = vec_fold(r_g, z_g);

  always_ff @(posedge clk) begin
    if (rst) begin
      vvld[0][0] <= 1'b0;
      vvld[1][0] <= 1'b0;
      g_vld      <= 1'b0;
    end else if (run) begin
      vvld[0][0] <= m2_vld;
      g_vld      <= vvld[0][N];
      vvld[1][0] <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      vx[0][0]    <= f0.x;
      vy[0][0]    <= f0.y;
      vacc[0][0]  <= f0.acc;
      vzero[0][0] <= (x2 == 0) && (y2 == 0);
      vaux[0][0]  <= z2;
      vcmd[0][0]  <= m2_cmd;
      r_g         <= qmul(vx[0][N], INV_GAIN);
      ang_g       <= vzero[0][N] ? '0 : vacc[0][N];
      z_g         <= vaux[0][N];
      g_cmd       <= vcmd[0][N];
      vx[1][0]    <= f1.x;
      vy[1][0]    <= f1.y;
      vacc[1][0]  <= f1.acc;
      vzero[1][0] <= (r_g == 0) && (z_g == 0);
      vaux[1][0]  <= ang_g;
      vcmd[1][0]  <= g_cmd;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_vec
    for (genvar i = 0; i < N; i++) begin : g_st
      always_ff @(posedge clk) begin
        if (rst) begin
          vvld[c][i+1] <= 1'b0;
        end else if (run) begin
          vvld[c][i+1] <= vvld[c][i];
        end
      end
      always_ff @(posedge clk) begin
        if (run) begin
          vzero[c][i+1] <= vzero[c][i];
          vaux[c][i+1]  <= vaux[c][i];
          vcmd[c][i+1]  <= vcmd[c][i];
          if (vy[c][i] >= 0) begin
            vx[c][i+1]   <= vx[c][i] + (vy[c][i] >>> i);
            vy[c][i+1]   <= vy[c][i] - (vx[c][i] >>> i);
            vacc[c][i+1] <= vacc[c][i] + atan_bam(i);
          end else begin
            vx[c][i+1]   <= vx[c][i] - (vy[c][i] >>> i);
            vy[c][i+1]   <= vy[c][i] + (vx[c][i] >>> i);
            vacc[c][i+1] <= vacc[c][i] - atan_bam(i);
          end
        end
      end
    end
  end

  // ---------------- output register ---------------------------------------
  logic signed [CW-1:0] lat_raw, lat_clip;
  logic [31:0]          ang_lo;
  assign lat_raw = vzero[1][N] ? '0 : vacc[1][N];
  assign ang_lo  = vaux[1][N][31:0];

  always_comb begin
    priority if (lat_raw > QUARTER) begin
      lat_clip = QUARTER;
    end else if (lat_raw < -QUARTER) begin
      lat_clip = -QUARTER;
    end else begin
      lat_clip = lat_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (run) begin
      result_valid <= vvld[1][N];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      result.lat_out <= lat_clip[31:0];
      result.lon_out <= (vcmd[1][N] == CMD_TO_EQU) ? POLE_RA + ang_lo : NODE_LON - ang_lo;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_on_held_result: assert property (@(posedge clk)
      item_stall == (result_valid && result_stall))
    else $error("item_stall does not follow a held result");

  a_lat_in_range: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> (result.lat_out <= 32'sd1073741824 &&
                        result.lat_out >= -32'sd1073741824))
    else $error("latitude outside a quarter turn");

  a_empty_after_reset: assert property (@(posedge clk)
      rst |=> !result_valid)
    else $error("result valid right after reset");

  a_held_result_frozen: assert property (@(posedge clk) disable iff (rst)
      (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("held result changed");
`endif

endmodule
`default_nettype wire

FILE: tb/egc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// egc_checker
// Watches both channels of the coordinate converter, predicts each result
// with a fixed-point CORDIC model of the sky rotation and compares in order.
// ---------------------------------------------------------------------------
module egc_checker
  import egc_pkg::*;
#(
  parameter int CORDIC_STAGES = 32
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     item_valid,
  input  wire     item_stall,
  input  item_t   item,
  input  wire     result_valid,
  input  wire     result_stall,
  input  result_t result,
  output int      errors,
  output int      pending
);

  localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam longint QTR = 64'sh40000000;
  localparam longint IGAIN = 64'sd652032874;

  result_t expected_q[$];

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> QONE_SHIFT;
  endfunction

  function automatic longint atan_step(int i);
    longint t;
    t = 0;
    case (i)
      0: t = 536870912;   1: t = 316933406;  2: t = 167458907;  3: t = 85004756;
      4: t = 42667331;    5: t = 21354465;   6: t = 10679838;   7: t = 5340245;
      8: t = 2670163;     9: t = 1335087;    10: t = 667544;    11: t = 333772;
      12: t = 166886;     13: t = 83443;     14: t = 41722;     15: t = 20861;
      16: t = 10430;      17: t = 5215;      18: t = 2608;      19: t = 1304;
      20: t = 652;        21: t = 326;       22: t = 163;       23: t = 81;
      24: t = 41;         25: t = 20;        26: t = 10;        27: t = 5;
      28: t = 3;          29: t = 1;         30: t = 1;
      default: t = 0;
    endcase
    return t;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint s,
                                 output longint c);
    logic [31:0] t;
    logic [31:0] tq;
    logic flip;
    longint z, x, y, nx;
    t = ang;
    tq = t + 32'h40000000;
    flip = tq[31];
    if (flip) t = t + 32'h80000000;
    z = longint'($signed(t));
    x = IGAIN;
    y = 0;
    for (int i = 0; i < NST; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic void heading(input longint xi, input longint yi, output longint ang,
                                  output longint mag);
    longint x, y, t, nx, acc;
    x = xi; y = yi; acc = 0;
    if (x == 0 && y == 0) begin
      ang = 0; mag = 0;
      return;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = QTR;
      end else begin
        t = x; x = -y; y = t; acc = -QTR;
      end
    end
    for (int i = 0; i < NST; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); acc += atan_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); acc -= atan_step(i);
      end
      x = nx;
    end
    ang = acc; mag = x;
  endfunction

  function automatic result_t sky_rotate(item_t it);
    result_t r;
    logic [31:0] h, a32;
    longint sp, cp, sd, cd, sh, ch, cdch, z, yv, xv, mag, rr, ang, lat;
    h = (it.command == CMD_TO_EQU) ? NODE_LON - it.lon_in : it.lon_in - POLE_RA;
    rotate(POLE_DEC, sp, cp);
    rotate(it.lat_in, sd, cd);
    rotate(h, sh, ch);
    cdch = qmul(cd, ch);
    z = qmul(sp, sd) + qmul(cp, cdch);
    yv = qmul(cd, sh);
    xv = qmul(cp, sd) - qmul(sp, cdch);
    heading(xv, yv, ang, mag);
    rr = qmul(mag, IGAIN);
    heading(rr, z, lat, mag);
    if (lat > QTR) lat = QTR;
    if (lat < -QTR) lat = -QTR;
    a32 = ang[31:0];
    r.lon_out = (it.command == CMD_TO_EQU) ? POLE_RA + a32 : NODE_LON - a32;
    r.lat_out = lat[31:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (item_valid && !item_stall) expected_q.push_back(sky_rotate(item));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result lon %h lat %h", $time,
                   result.lon_out, result.lat_out);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.lon_out !== result.lon_out || want.lat_out !== result.lat_out) begin
            $display("%0t: mismatch expected lon %h lat %h, actual lon %h lat %h",
                     $time, want.lon_out, want.lat_out, result.lon_out, result.lat_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/equatorial_galactic_convert_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// equatorial_galactic_convert_tb
// Directed and random sky positions in both directions with random gaps
// and stalls, including one long output hold-off that backs up the pipe.
// ---------------------------------------------------------------------------
module equatorial_galactic_convert_tb;
  import egc_pkg::*;

  localparam int NUM_RANDOM = 2000;
  localparam int LATENCY = 3 * 32 + 6;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      errors, pending;
  bit      hold_done = 1'b0;
  int      sent = 0;

  always #6 clk = ~clk;

  equatorial_galactic_convert u_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  egc_checker u_chk (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .result_valid(result_valid), .result_stall(result_stall),
    .result(result), .errors(errors), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t random_position();
    item_t it;
    int p;
    it.command = 1'($urandom_range(0, 1));
    it.lon_in = $urandom;
    p = $urandom_range(0, 9);
    if (p < 7) it.lat_in = $signed($urandom_range(0, 32'h80000000)) - 32'sh40000000;
    else it.lat_in = $urandom;  // beyond a quarter turn wraps
    return it;
  endfunction

  task automatic send(input item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  // receiver: one long hold-off once, then random stalls, none while sent is between 1500 and 1700
  initial begin
    @(posedge clk iff !rst);
    while (sent < 40) @(posedge clk);
    result_stall <= 1'b1;
    repeat (300) @(posedge clk);
    result_stall <= 1'b0;
    hold_done = 1'b1;
    forever begin
      repeat (gap_len()) @(posedge clk);
      if (sent > 1500 && sent < 1700) begin
        @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin
    item_t it;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, poles, node and pole longitudes, both commands
    for (int c = 0; c < 2; c++) begin
      it.command = c[0];
      it.lon_in = 32'h0;          it.lat_in = 32'sh0;          send(it);
      it.lon_in = 32'hFFFFFFFF;   it.lat_in = 32'sh40000000;   send(it);
      it.lon_in = 32'h80000000;   it.lat_in = -32'sh40000000;  send(it);
      it.lon_in = POLE_RA;        it.lat_in = POLE_DEC;        send(it);
      it.lon_in = NODE_LON;       it.lat_in = 32'sh7FFFFFFF;   send(it);
      it.lon_in = 32'h55555555;   it.lat_in = 32'sh80000000;   send(it);
      it.lon_in = 32'hAAAAAAAA;   it.lat_in = 32'sh3FFFFFFF;   send(it);
      it.lon_in = NODE_LON + 32'h80000000; it.lat_in = -32'sh3FFFFFFF; send(it);
    end
    // north poles: forward from the celestial pole, back from the galactic pole
    it.command = CMD_TO_GAL; it.lon_in = POLE_RA; it.lat_in = 32'sh40000000; send(it);
    it.command = CMD_TO_EQU; it.lon_in = NODE_LON; it.lat_in = 32'sh40000000; send(it);
    for (k = 0; k < NUM_RANDOM; k++) send(random_position());
    item_valid <= 1'b0;
    while (!hold_done || pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("equatorial_galactic_convert_tb: clean");
    else $display("equatorial_galactic_convert_tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("equatorial_galactic_convert_tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/egc_pkg.sv
rtl/equatorial_galactic_convert.sv
tb/egc_checker.sv
tb/equatorial_galactic_convert_tb.sv
